// ===== src/event_trace_ring_buffer_top_assert.svh =====
// Assertion macros shared by the trace buffer RTL.
`ifndef EVENT_TRACE_RING_BUFFER_TOP_ASSERT_SVH
`define EVENT_TRACE_RING_BUFFER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ETRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ETRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ETRB_ASSERT(label, prop, msg)
`define ETRB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/etrb_pkg.sv =====
// Types and constants shared by the event trace ring buffer modules.
`default_nettype none

package etrb_pkg;

  // Operation codes carried in the input tuser.
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_BOOT  = 3'd1,
    OP_READ  = 3'd2,
    OP_DRAIN = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  localparam int CNT_W       = 32;
  localparam int HELD_W      = 7;
  localparam int AGE_W       = 6;
  localparam int IN_DATA_W   = 128;
  localparam int OUT_DATA_W  = 232;
  localparam logic [1:0] SEV_INFO      = 2'd1;
  localparam logic [1:0] MIN_LEVEL_RST = 2'd1;

  typedef logic [HELD_W-1:0] held_t;

  // One stored trace record.
  typedef struct packed {
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_a;
    logic [15:0]        code;
    logic [7:0]         src_mod;
    logic [1:0]         sev;
    logic [31:0]        time_ms;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // One accepted input item.
  typedef struct packed {
    op_t              op;
    rec_t             rec;
    logic [AGE_W-1:0] age;
  } item_t;

  // One result item handed to the output queue.
  typedef struct packed {
    logic             valid;
    rec_t             rec;
    held_t            held;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] boots;
    logic [CNT_W-1:0] pend;
    logic             last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/etrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module etrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/etrb_out.sv =====
// Two-entry result queue that packs results onto the master stream.
`default_nettype none

module etrb_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  etrb_pkg::result_t               res,
  output logic                            space,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0 up: rec_time, rec_severity, rec_module, rec_code, rec_a, rec_b,
  // held_count, total_written, boot_count, pending_count, zero fill.
  output logic [etrb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Field: rec_valid.
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

`include "event_trace_ring_buffer_top_assert.svh"

  localparam int PAD_W = etrb_pkg::OUT_DATA_W - ($bits(etrb_pkg::result_t) - 2);

  logic [1:0]        count;
  logic [1:0]        count_after_pop;
  logic              pop;
  etrb_pkg::result_t slot0;
  etrb_pkg::result_t slot1;

  assign pop             = m_axis_tvalid && m_axis_tready;
  assign space           = (count != 2'd2);
  assign count_after_pop = pop ? (count - 2'd1) : count;

  // Head slot shifts forward on a transfer; a new result fills the first free slot.
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (count_after_pop == 2'd0) begin
        slot0 <= res;
      end else begin
        slot1 <= res;
      end
    end
  end

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_after_pop + {1'b0, push};
    end
  end

  // Stream packing of the head slot.
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tuser  = slot0.valid;
  assign m_axis_tlast  = slot0.last;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, slot0.pend, slot0.boots, slot0.total, slot0.held,
                          slot0.rec.arg_b, slot0.rec.arg_a, slot0.rec.code,
                          slot0.rec.src_mod, slot0.rec.sev, slot0.rec.time_ms};

  `ETRB_ASSERT(a_no_overflow, push |-> count != 2'd2, "result pushed into a full queue")
  `ETRB_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 2'd1, "fill count slip")
  `ETRB_ASSERT_NEXT(a_drain, pop && !push, count == $past(count) - 2'd1, "drain count slip")

endmodule

`default_nettype wire

// ===== src/etrb_ctrl.sv =====
// Sequencer: decodes operations, keeps pointers and counters, drives the record memory.
`default_nettype none

module etrb_ctrl #(
  parameter int CAPACITY = 64,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  etrb_pkg::item_t             item,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_wdata,
  input  logic                        space,
  output logic                        push,
  output etrb_pkg::result_t           res,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [etrb_pkg::REC_W-1:0]  ram_wdata,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [etrb_pkg::REC_W-1:0]  ram_rdata
);

`include "event_trace_ring_buffer_top_assert.svh"

  localparam int HW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
  localparam logic [HW-1:0] CAP_H    = HW'(CAPACITY);
  localparam logic [AW:0]   CAP_X    = (AW + 1)'(CAPACITY);

  typedef enum logic {ST_IDLE, ST_FETCH} state_t;

  state_t                      state, state_next;
  logic [1:0]                  min_level;
  logic [AW-1:0]               wp, wp_next;
  logic [AW-1:0]               base, base_next;
  logic [HW-1:0]               held, held_next;
  logic [etrb_pkg::CNT_W-1:0]  written, written_next;
  logic [etrb_pkg::CNT_W-1:0]  flushed, flushed_next;
  logic [etrb_pkg::CNT_W-1:0]  boots, boots_next;
  logic [HW-1:0]               remain, remain_next;
  logic [AW-1:0]               rd_addr, rd_addr_next;

  logic                        fire;
  logic                        full;
  logic [AW-1:0]               wp_inc;
  logic [etrb_pkg::CNT_W-1:0]  diff;
  logic                        has_pend;
  logic                        diff_over;
  logic [HW-1:0]               drain_n;
  logic [HW-1:0]               drain_off;
  logic [AW-1:0]               drain_addr;
  logic [AW-1:0]               read_addr;
  logic                        age_ok;
  etrb_pkg::rec_t              boot_rec;

  // Ring index arithmetic modulo the capacity.
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] x);
    return (x == LAST_IDX) ? '0 : (x + 1'b1);
  endfunction

  function automatic logic [AW-1:0] idx_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= CAP_X) begin
      s = s - CAP_X;
    end
    return s[AW-1:0];
  endfunction

  assign in_ready = (state == ST_IDLE) && space;
  assign fire     = in_valid && in_ready;

  // Values shared by the decode below.
  assign full      = (held == CAP_H);
  assign wp_inc    = idx_inc(wp);
  assign diff      = written - flushed;
  assign has_pend  = (written > flushed);
  assign diff_over = (diff > etrb_pkg::CNT_W'(held));
  assign drain_n   = diff_over ? held : HW'(diff);
  assign drain_off = diff_over ? '0 : (held - HW'(diff));
  assign drain_addr = idx_add(base, AW'(drain_off));
  assign read_addr = idx_add(base, AW'(item.age));
  assign age_ok    = (etrb_pkg::held_t'(item.age) < etrb_pkg::held_t'(held));

  always_comb begin
    boot_rec       = item.rec;
    boot_rec.sev   = etrb_pkg::SEV_INFO;
    boot_rec.arg_b = boots + 1'b1;
  end

  // Operation decode and fetch sequencing.
  always_comb begin
    state_next   = state;
    wp_next      = wp;
    base_next    = base;
    held_next    = held;
    written_next = written;
    flushed_next = flushed;
    boots_next   = boots;
    remain_next  = remain;
    rd_addr_next = rd_addr;
    push         = 1'b0;
    res          = '0;
    ram_we       = 1'b0;
    ram_waddr    = wp;
    ram_wdata    = item.rec;
    ram_re       = 1'b0;
    ram_raddr    = rd_addr;

    case (state)
      ST_IDLE: begin
        if (fire) begin
          case (item.op)
            etrb_pkg::OP_WRITE, etrb_pkg::OP_BOOT: begin
              if (item.op == etrb_pkg::OP_BOOT || item.rec.sev >= min_level) begin
                ram_we       = 1'b1;
                wp_next      = wp_inc;
                base_next    = full ? wp_inc : base;
                held_next    = full ? held : (held + 1'b1);
                written_next = written + 1'b1;
                res.valid    = 1'b1;
                res.rec      = item.rec;
                if (item.op == etrb_pkg::OP_BOOT) begin
                  boots_next = boots + 1'b1;
                  ram_wdata  = boot_rec;
                  res.rec    = boot_rec;
                end
              end
              push     = 1'b1;
              res.last = 1'b1;
            end
            etrb_pkg::OP_READ: begin
              if (age_ok) begin
                ram_re       = 1'b1;
                ram_raddr    = read_addr;
                rd_addr_next = read_addr;
                remain_next  = HW'(1);
                state_next   = ST_FETCH;
              end else begin
                push     = 1'b1;
                res.last = 1'b1;
              end
            end
            etrb_pkg::OP_DRAIN: begin
              if (has_pend) begin
                flushed_next = written;
              end
              if (has_pend && drain_n != '0) begin
                ram_re       = 1'b1;
                ram_raddr    = drain_addr;
                rd_addr_next = drain_addr;
                remain_next  = drain_n;
                state_next   = ST_FETCH;
              end else begin
                push     = 1'b1;
                res.last = 1'b1;
              end
            end
            etrb_pkg::OP_CLEAR: begin
              wp_next      = '0;
              base_next    = '0;
              held_next    = '0;
              written_next = '0;
              flushed_next = '0;
              boots_next   = '0;
              push         = 1'b1;
              res.last     = 1'b1;
            end
            default: begin
              push     = 1'b1;
              res.last = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Memory output holds until the queue can take the record.
        if (space) begin
          push        = 1'b1;
          res.valid   = 1'b1;
          res.rec     = etrb_pkg::rec_t'(ram_rdata);
          res.last    = (remain == HW'(1));
          remain_next = remain - 1'b1;
          if (remain == HW'(1)) begin
            state_next = ST_IDLE;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = idx_inc(rd_addr);
            rd_addr_next = idx_inc(rd_addr);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Counters in every result reflect the state after the whole operation.
    res.held  = etrb_pkg::held_t'(held_next);
    res.total = written_next;
    res.boots = boots_next;
    res.pend  = (written_next > flushed_next) ? (written_next - flushed_next) : '0;
  end

  // State, pointers, counters and the level register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      min_level <= etrb_pkg::MIN_LEVEL_RST;
      wp        <= '0;
      base      <= '0;
      held      <= '0;
      written   <= '0;
      flushed   <= '0;
      boots     <= '0;
      remain    <= '0;
      rd_addr   <= '0;
    end else begin
      state   <= state_next;
      wp      <= wp_next;
      base    <= base_next;
      held    <= held_next;
      written <= written_next;
      flushed <= flushed_next;
      boots   <= boots_next;
      remain  <= remain_next;
      rd_addr <= rd_addr_next;
      if (cfg_we) begin
        min_level <= cfg_wdata;
      end
    end
  end

  `ETRB_ASSERT(a_no_write_in_fetch, state == ST_FETCH |-> !ram_we, "memory write during fetch")
  `ETRB_ASSERT(a_hold_read, state == ST_FETCH && !space |-> !ram_re, "read data overwritten")
  `ETRB_ASSERT_NEXT(a_fetch_done, state == ST_FETCH && push && res.last, state == ST_IDLE, "stuck")
  `ETRB_ASSERT_NEXT(a_held_stable, state == ST_FETCH, $stable(held), "held moved during fetch")

endmodule

`default_nettype wire

// ===== src/event_trace_ring_buffer_top.sv =====
// Items that need no memory read are queued at their transfer edge and then offered on the
// master stream; such items are taken every cycle while the result queue has room. A read
// returns its record from the registered memory read via the result queue. A drain does
// the same, one record per cycle while the queue has room, paced by the single read port of the
// record memory; the next item is taken once the last result of the current one is queued.
// Reset is synchronous: pointers and counters clear, min_level returns to info, memory is kept.
`default_nettype none

module event_trace_ring_buffer_top #(
  parameter int CAPACITY = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0 up: timestamp_ms, severity, source_module, event_code, arg_a, arg_b,
  // age_index.
  input  logic [etrb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Field: op.
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0 up: rec_time, rec_severity, rec_module, rec_code, rec_a, rec_b,
  // held_count, total_written, boot_count, pending_count, zero fill.
  output logic [etrb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Field: rec_valid.
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_wdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  etrb_pkg::item_t             item;
  etrb_pkg::result_t           res;
  logic                        push;
  logic                        space;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [etrb_pkg::REC_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [etrb_pkg::REC_W-1:0]  ram_rdata;

  // Unpack the slave stream into an item.
  always_comb begin
    item.op          = etrb_pkg::op_t'(s_axis_tuser);
    item.rec.time_ms = s_axis_tdata[31:0];
    item.rec.sev     = s_axis_tdata[33:32];
    item.rec.src_mod = s_axis_tdata[41:34];
    item.rec.code    = s_axis_tdata[57:42];
    item.rec.arg_a   = s_axis_tdata[89:58];
    item.rec.arg_b   = s_axis_tdata[121:90];
    item.age         = s_axis_tdata[127:122];
  end

  etrb_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .space     (space),
    .push      (push),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  etrb_ram #(
    .WIDTH (etrb_pkg::REC_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  etrb_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .space         (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== sim/event_trace_ring_buffer_checker.sv =====
// Checker that predicts the trace buffer results and compares every output transfer.
module event_trace_ring_buffer_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [231:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         m_axis_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,
  output int           fail_count,
  output int           results_seen,
  output int           outstanding
);

  localparam int DEPTH = 64;

  // One trace record as the buffer stores it.
  typedef struct packed {
    logic [31:0] stamp;
    logic [1:0]  sev;
    logic [7:0]  src;
    logic [15:0] code;
    logic [31:0] arg_a;
    logic [31:0] arg_b;
  } trace_entry_t;

  // One output transfer: the record plus the counters after the operation.
  typedef struct packed {
    logic         ok;
    trace_entry_t entry;
    logic [6:0]   held;
    logic [31:0]  total;
    logic [31:0]  boots;
    logic [31:0]  pend;
    logic         tail;
  } outcome_t;

  trace_entry_t ring [DEPTH];
  logic [5:0]   wr_ptr;
  logic [6:0]   held;
  logic [31:0]  written;
  logic [31:0]  flushed;
  logic [31:0]  boots;
  logic [1:0]   floor_level;
  outcome_t     awaited [$];
  int           failures = 0;
  int           checked = 0;

  initial begin
    fail_count   = 0;
    results_seen = 0;
    outstanding  = 0;
  end

  // Empties the buffer and zeroes the counters; the level floor is kept.
  function automatic void clear_trace();
    wr_ptr  = '0;
    held    = '0;
    written = '0;
    flushed = '0;
    boots   = '0;
  endfunction

  function automatic void store_entry(input trace_entry_t e);
    ring[wr_ptr] = e;
    wr_ptr = wr_ptr + 6'd1;
    if (held < 7'(DEPTH)) held = held + 7'd1;
    written = written + 32'd1;
  endfunction

  // Record at a given age, counted from the oldest one held.
  function automatic trace_entry_t entry_at(input int age);
    int start;
    start = (int'(wr_ptr) + DEPTH - int'(held)) % DEPTH;
    return ring[(start + age) % DEPTH];
  endfunction

  // Queues one expected transfer carrying the counters as they stand now.
  function automatic void owe(input logic ok, input trace_entry_t e, input logic tail);
    outcome_t o;
    o.ok    = ok;
    o.entry = e;
    o.held  = held;
    o.total = written;
    o.boots = boots;
    o.pend  = (written > flushed) ? written - flushed : 32'd0;
    o.tail  = tail;
    awaited.push_back(o);
  endfunction

  // Applies one accepted input transfer to the buffer state.
  function automatic void advance_trace(input logic [2:0] op, input logic [127:0] d);
    trace_entry_t e;
    trace_entry_t blank;
    logic [31:0]  from;
    logic [31:0]  upto;
    logic [31:0]  n;
    int           i;
    e.stamp = d[31:0];
    e.sev   = d[33:32];
    e.src   = d[41:34];
    e.code  = d[57:42];
    e.arg_a = d[89:58];
    e.arg_b = d[121:90];
    blank   = '0;
    case (op)
      etrb_pkg::OP_WRITE: begin
        if (e.sev < floor_level) begin
          owe(1'b0, blank, 1'b1);
        end else begin
          store_entry(e);
          owe(1'b1, e, 1'b1);
        end
      end
      etrb_pkg::OP_BOOT: begin
        boots = boots + 32'd1;
        e.sev = etrb_pkg::SEV_INFO;
        e.arg_b = boots;
        store_entry(e);
        owe(1'b1, e, 1'b1);
      end
      etrb_pkg::OP_READ: begin
        if ({1'b0, d[127:122]} < held) owe(1'b1, entry_at(int'(d[127:122])), 1'b1);
        else owe(1'b0, blank, 1'b1);
      end
      etrb_pkg::OP_DRAIN: begin
        from = flushed;
        upto = written;
        if (from >= upto) begin
          owe(1'b0, blank, 1'b1);
        end else begin
          // Records overwritten before the drain count as flushed.
          if (upto - from > {25'd0, held}) from = upto - {25'd0, held};
          n = upto - from;
          flushed = upto;
          if (n == 32'd0) begin
            owe(1'b0, blank, 1'b1);
          end else begin
            for (i = 0; i < int'(n); i++) begin
              owe(1'b1, entry_at(int'(held) - int'(n) + i), (i + 1) == int'(n));
            end
          end
        end
      end
      etrb_pkg::OP_CLEAR: begin
        clear_trace();
        owe(1'b0, blank, 1'b1);
      end
      default: begin
        owe(1'b0, blank, 1'b1);
      end
    endcase
  endfunction

  function automatic void flag_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      failures++;
      if (failures <= 10) begin
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 name, checked, want, got);
      end
    end
  endfunction

  // Compares one output transfer with the oldest expectation.
  function automatic void compare_output();
    outcome_t     want;
    logic [231:0] d;
    d = m_axis_tdata;
    checked++;
    if (awaited.size() == 0) begin
      failures++;
      if (failures <= 10) $display("result %0d arrived with nothing expected", checked);
    end else begin
      want = awaited.pop_front();
      flag_field("rec_valid", 32'(want.ok), 32'(m_axis_tuser));
      flag_field("rec_time", want.entry.stamp, d[31:0]);
      flag_field("rec_severity", 32'(want.entry.sev), 32'(d[33:32]));
      flag_field("rec_module", 32'(want.entry.src), 32'(d[41:34]));
      flag_field("rec_code", 32'(want.entry.code), 32'(d[57:42]));
      flag_field("rec_a", want.entry.arg_a, d[89:58]);
      flag_field("rec_b", want.entry.arg_b, d[121:90]);
      flag_field("held_count", 32'(want.held), 32'(d[128:122]));
      flag_field("total_written", want.total, d[160:129]);
      flag_field("boot_count", want.boots, d[192:161]);
      flag_field("pending_count", want.pend, d[224:193]);
      flag_field("last", 32'(want.tail), 32'(m_axis_tlast));
    end
  endfunction

  // Inputs are sampled as they stood before the edge; counts leave by nonblocking update.
  always @(posedge clk) begin
    if (rst) begin
      clear_trace();
      floor_level = etrb_pkg::MIN_LEVEL_RST;
      awaited.delete();
    end else begin
      if (cfg_we) floor_level = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) advance_trace(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_output();
    end
    outstanding  <= awaited.size();
    fail_count   <= failures;
    results_seen <= checked;
  end

endmodule

// ===== sim/tb_event_trace_ring_buffer_top.sv =====
// Testbench top that drives the trace buffer and reports the checker's verdict.
module tb_event_trace_ring_buffer_top;

  localparam int LIMIT = 2000000;
  // Operation codes the block does not define.
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [231:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_wdata = '0;
  int           fail_count;
  int           results_seen;
  int           outstanding;
  int           cycles = 0;
  int           op_tally [8];
  bit           steady = 1'b0;

  event_trace_ring_buffer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  event_trace_ring_buffer_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .results_seen  (results_seen),
    .outstanding   (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the handshakes never complete.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("tb_event_trace_ring_buffer_top: errors");
      $finish;
    end
  end

  // Idle cycles before a transfer; none at all during steady stretches.
  function automatic int draw_idle();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Result side: stalls a random number of cycles before each transfer.
  initial begin
    int stall;
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Offers one item and returns at the edge where its transfer completes.
  task automatic send_item(input logic [2:0] op, input logic [31:0] stamp,
                           input logic [1:0] sev, input logic [7:0] src,
                           input logic [15:0] code, input logic [31:0] arg_a,
                           input logic [31:0] arg_b, input logic [5:0] age);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {age, arg_b, arg_a, code, src, sev, stamp};
    s_axis_tuser  <= op;
    op_tally[op]++;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_random(input logic [2:0] op);
    logic [5:0] age;
    age = $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
    send_item(op, $urandom, 2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
              $urandom, $urandom, age);
  endtask

  // Mostly writes and reads, with drains often enough to keep records flowing.
  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 48) return etrb_pkg::OP_WRITE;
    if (r < 56) return etrb_pkg::OP_BOOT;
    if (r < 78) return etrb_pkg::OP_READ;
    if (r < 90) return etrb_pkg::OP_DRAIN;
    if (r < 93) return etrb_pkg::OP_CLEAR;
    if (r < 96) return 3'($urandom_range(OP_RSVD_A, OP_RSVD_C));
    return etrb_pkg::OP_WRITE;
  endfunction

  // Holds the sender until every expected result has been transferred.
  task automatic wait_for_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_level(input logic [1:0] level);
    wait_for_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [1:0] levels [4];
    int         p;
    int         k;
    levels = '{2'd3, 2'd2, 2'd0, 2'd1};
    foreach (op_tally[j]) op_tally[j] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset level: empty buffer, extremes, boot, drains, reserved codes.
    send_item(etrb_pkg::OP_READ, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_DRAIN, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_WRITE, '1, 2'd0, '1, '1, '1, '1, '1);
    send_item(etrb_pkg::OP_WRITE, 32'hFFFF_FFFF, 2'd3, 8'hFF, 16'hFFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 6'd0);
    send_item(etrb_pkg::OP_WRITE, '0, 2'd1, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_WRITE, 32'd1, 2'd2, 8'd1, 16'd1, 32'hFFFF_FFFF, '0, 6'd63);
    send_item(etrb_pkg::OP_BOOT, 32'd500, 2'd0, 8'h10, 16'h20, 32'd3, 32'hDEAD_BEEF, 6'd0);
    send_item(etrb_pkg::OP_READ, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_READ, '0, 2'd0, '0, '0, '0, '0, 6'd3);
    send_item(etrb_pkg::OP_READ, '0, 2'd0, '0, '0, '0, '0, 6'd4);
    send_item(etrb_pkg::OP_READ, '1, 2'd3, '1, '1, '1, '1, 6'd63);
    send_item(etrb_pkg::OP_DRAIN, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_DRAIN, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(OP_RSVD_A, '1, 2'd3, '1, '1, '1, '1, '1);
    send_item(OP_RSVD_B, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(OP_RSVD_C, 32'd7, 2'd1, 8'd7, 16'd7, 32'd7, 32'd7, 6'd1);
    send_item(etrb_pkg::OP_CLEAR, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_READ, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_DRAIN, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_BOOT, '1, 2'd3, 8'hFF, 16'hFFFF, 32'h7FFF_FFFF, '0, 6'd0);

    // Wrap the buffer with every level stored, then drain more than it holds.
    set_level(2'd0);
    steady = 1'b1;
    for (k = 0; k < 70; k++) send_random(etrb_pkg::OP_WRITE);
    steady = 1'b0;
    send_item(etrb_pkg::OP_READ, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_READ, '0, 2'd0, '0, '0, '0, '0, 6'd63);
    send_item(etrb_pkg::OP_DRAIN, '0, 2'd0, '0, '0, '0, '0, 6'd0);
    send_item(etrb_pkg::OP_DRAIN, '0, 2'd0, '0, '0, '0, '0, 6'd0);

    // Random traffic under each level, with steady stretches now and then.
    for (p = 0; p < 4; p++) begin
      set_level(levels[p]);
      for (k = 0; k < 77; k++) begin
        if (k % 25 == 0) steady = ($urandom_range(0, 2) == 0);
        if (p == 1 && k == 50) wait_for_quiet();
        send_random(pick_op());
      end
    end
    steady = 1'b0;

    wait_for_quiet();
    repeat (20) @(posedge clk);
    $display("Sent %0d writes, %0d boots, %0d reads, %0d drains, %0d clears, %0d reserved ops.",
             op_tally[etrb_pkg::OP_WRITE], op_tally[etrb_pkg::OP_BOOT],
             op_tally[etrb_pkg::OP_READ], op_tally[etrb_pkg::OP_DRAIN],
             op_tally[etrb_pkg::OP_CLEAR],
             op_tally[OP_RSVD_A] + op_tally[OP_RSVD_B] + op_tally[OP_RSVD_C]);
    $display("Checked %0d results over min levels 0 to 3, including a drain past a wrap.",
             results_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_event_trace_ring_buffer_top: clean");
    end else begin
      $display("tb_event_trace_ring_buffer_top: errors");
    end
    $finish;
  end

endmodule
